// ===== rtl/tsched_pkg.sv =====
// ----------------------------------------------------------------------------
// tsched_pkg
// shared types and constants of the task scheduler: table sizes, policy and
// item kind codes, and the per-cycle step word that drives the picker
// ----------------------------------------------------------------------------
package tsched_pkg;

  localparam int unsigned NumTasks = 16;
  localparam int unsigned TaskW    = $clog2(NumTasks);
  localparam int unsigned PrioW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PolicyW  = 2;

  localparam logic [PolicyW-1:0] PolicyRr   = 2'd0;
  localparam logic [PolicyW-1:0] PolicyPrio = 2'd1;
  localparam logic [PolicyW-1:0] PolicyEdf  = 2'd2;

  localparam logic KindWrite   = 1'b0;
  localparam logic KindRequest = 1'b1;

  typedef struct packed {
    logic                     clear;
    logic                     step;
    logic [TaskW-1:0]         idx;
    logic                     rdy;
    logic signed [PrioW-1:0]  prio;
    logic [TimeW-1:0]         ltime;
    logic [TaskW-1:0]         cur;
    logic [PolicyW-1:0]       policy;
  } step_t;

  typedef struct packed {
    logic             found;
    logic [TaskW-1:0] task_id;
  } pick_t;

endpackage

// ===== rtl/task_scheduler_rr_prio_edf_unit.sv =====
// ----------------------------------------------------------------------------
// task_scheduler_rr_prio_edf_unit
// write word: busy stays low. request word: scans the 16 table entries one per
// cycle in StScan, then StFinish registers the result together with the strobe;
// busy is low again in the strobe cycle, so the next word can be accepted there
// but not while busy. the scan is most of the busy time; receiver cannot stall
// reset clears policy (round robin) and both tables to zero
// ----------------------------------------------------------------------------
module task_scheduler_rr_prio_edf_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   kind_i,
  input  logic [tsched_pkg::TaskW-1:0]           task_req_i,
  input  logic signed [tsched_pkg::PrioW-1:0]    priority_req_i,
  input  logic [tsched_pkg::TimeW-1:0]           left_time_i,
  input  logic [tsched_pkg::NumTasks-1:0]        ready_mask_i,
  output logic                                   result_valid_o,
  output logic [tsched_pkg::TaskW-1:0]           next_task_o,
  output logic                                   found_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tsched_pkg::PolicyW-1:0]         cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e                                state_q;
  logic [tsched_pkg::PolicyW-1:0]        policy_q;
  logic [tsched_pkg::NumTasks-1:0]       mask_q;
  logic [tsched_pkg::TaskW-1:0]          cur_q;
  logic [tsched_pkg::TaskW-1:0]          idx_q;
  logic                                  result_valid_q;
  logic [tsched_pkg::TaskW-1:0]          next_task_q;
  logic                                  found_q;
  logic signed [tsched_pkg::PrioW-1:0]   prio_tab_q [tsched_pkg::NumTasks];
  logic [tsched_pkg::TimeW-1:0]          time_tab_q [tsched_pkg::NumTasks];
  logic                                  accept;
  tsched_pkg::step_t                     step;
  tsched_pkg::pick_t                     pick;

  assign accept      = start && !busy;
  assign busy        = state_q != StIdle;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    step.clear  = accept;
    step.step   = state_q == StScan;
    step.idx    = idx_q;
    step.rdy    = mask_q[idx_q];
    step.prio   = prio_tab_q[idx_q];
    step.ltime  = time_tab_q[idx_q];
    step.cur    = cur_q;
    step.policy = policy_q;
  end

  tsched_pick u_pick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .pick_o (pick)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= tsched_pkg::PolicyRr;
    end else if (cfg_valid_i && cfg_ready_o) begin
      policy_q <= cfg_data_i;
    end
  end

  // task table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tsched_pkg::NumTasks; i++) begin
        prio_tab_q[i] <= '0;
        time_tab_q[i] <= '0;
      end
    end else if (accept && kind_i == tsched_pkg::KindWrite) begin
      prio_tab_q[task_req_i] <= priority_req_i;
      time_tab_q[task_req_i] <= left_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      idx_q          <= '0;
      result_valid_q <= 1'b0;
      mask_q         <= '0;
      cur_q          <= '0;
      next_task_q    <= '0;
      found_q        <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept && kind_i == tsched_pkg::KindRequest) begin
            mask_q  <= ready_mask_i;
            cur_q   <= task_req_i;
            idx_q   <= '0;
            state_q <= StScan;
          end
        end
        StScan: begin
          idx_q <= idx_q + tsched_pkg::TaskW'(1);
          if (idx_q == tsched_pkg::TaskW'(tsched_pkg::NumTasks - 1)) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          next_task_q    <= pick.task_id;
          found_q        <= pick.found;
          result_valid_q <= 1'b1;
          state_q        <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign next_task_o    = next_task_q;
  assign found_o        = found_q;

endmodule

// ===== rtl/tsched_pick.sv =====
// ----------------------------------------------------------------------------
// tsched_pick
// scan accumulator: takes one table entry per cycle while step is high and keeps the running
// candidates of all three policies, then resolves the chosen task
// ----------------------------------------------------------------------------
module tsched_pick (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsched_pkg::step_t  step_i,
  output tsched_pkg::pick_t  pick_o
);

  logic [1:0]                        cnt_q, cnt_d;
  logic [tsched_pkg::TaskW-1:0]      first_q, first_d;
  logic [tsched_pkg::TaskW-1:0]      second_q, second_d;
  logic [tsched_pkg::TaskW-1:0]      up_q, up_d;
  logic                              up_vld_q, up_vld_d;
  logic [tsched_pkg::TimeW-1:0]      edf_best_q, edf_best_d;
  logic [tsched_pkg::TaskW-1:0]      edf_task_q, edf_task_d;
  logic signed [tsched_pkg::PrioW:0] pr_best_q, pr_best_d;
  logic [tsched_pkg::TaskW-1:0]      pr_high_q, pr_high_d;
  logic [tsched_pkg::TaskW-1:0]      pr_below_q, pr_below_d;
  logic                              pr_below_vld_q, pr_below_vld_d;
  logic                              pr_cur_in_q, pr_cur_in_d;
  logic signed [tsched_pkg::PrioW:0] prio_ext;
  logic                              is_below;
  logic                              is_cur;

  assign prio_ext = {step_i.prio[tsched_pkg::PrioW-1], step_i.prio};
  assign is_below = step_i.idx < step_i.cur;
  assign is_cur   = step_i.idx == step_i.cur;

  always_comb begin
    cnt_d          = cnt_q;
    first_d        = first_q;
    second_d       = second_q;
    up_d           = up_q;
    up_vld_d       = up_vld_q;
    edf_best_d     = edf_best_q;
    edf_task_d     = edf_task_q;
    pr_best_d      = pr_best_q;
    pr_high_d      = pr_high_q;
    pr_below_d     = pr_below_q;
    pr_below_vld_d = pr_below_vld_q;
    pr_cur_in_d    = pr_cur_in_q;
    if (step_i.clear) begin
      cnt_d          = 2'd0;
      up_vld_d       = 1'b0;
      edf_best_d     = '1;
      pr_best_d      = -(tsched_pkg::PrioW+1)'(129);
      pr_below_vld_d = 1'b0;
      pr_cur_in_d    = 1'b0;
    end else if (step_i.step && step_i.rdy) begin
      if (cnt_q != 2'd2) begin
        cnt_d = cnt_q + 2'd1;
      end
      if (cnt_q == 2'd0) begin
        first_d    = step_i.idx;
        edf_task_d = step_i.idx;
      end
      if (cnt_q == 2'd1) begin
        second_d = step_i.idx;
      end
      if (!is_below && !is_cur && !up_vld_q) begin
        up_d     = step_i.idx;
        up_vld_d = 1'b1;
      end
      if (step_i.ltime < edf_best_q) begin
        edf_best_d = step_i.ltime;
        edf_task_d = step_i.idx;
      end
      // priority: a higher level restarts the top group
      if (prio_ext > pr_best_q) begin
        pr_best_d      = prio_ext;
        pr_high_d      = step_i.idx;
        pr_below_d     = step_i.idx;
        pr_below_vld_d = is_below;
        pr_cur_in_d    = is_cur;
      end else if (prio_ext == pr_best_q) begin
        pr_high_d = step_i.idx;
        if (is_below) begin
          pr_below_d     = step_i.idx;
          pr_below_vld_d = 1'b1;
        end
        if (is_cur) begin
          pr_cur_in_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q          <= 2'd0;
      up_vld_q       <= 1'b0;
      pr_below_vld_q <= 1'b0;
      pr_cur_in_q    <= 1'b0;
    end else begin
      cnt_q          <= cnt_d;
      up_vld_q       <= up_vld_d;
      pr_below_vld_q <= pr_below_vld_d;
      pr_cur_in_q    <= pr_cur_in_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= first_d;
    second_q   <= second_d;
    up_q       <= up_d;
    edf_best_q <= edf_best_d;
    edf_task_q <= edf_task_d;
    pr_best_q  <= pr_best_d;
    pr_high_q  <= pr_high_d;
    pr_below_q <= pr_below_d;
  end

  always_comb begin
    pick_o.found   = 1'b1;
    pick_o.task_id = first_q;
    unique case (cnt_q)
      2'd0: begin
        pick_o.found   = 1'b0;
        pick_o.task_id = '0;
      end
      2'd1: pick_o.task_id = first_q;
      default: begin
        priority if (step_i.policy[1]) begin
          pick_o.task_id = edf_task_q;
        end else if (step_i.policy == tsched_pkg::PolicyPrio) begin
          pick_o.task_id = (pr_cur_in_q && pr_below_vld_q) ? pr_below_q : pr_high_q;
        end else begin
          pick_o.task_id = up_vld_q ? up_q : second_q;
        end
      end
    endcase
  end

endmodule

// ===== rtl/tsched_chk.sv =====
// ----------------------------------------------------------------------------
// tsched_chk
// port-level checks of the task scheduler, bound to the top level
// ----------------------------------------------------------------------------
module tsched_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         kind_i,
  input logic                         result_valid_o,
  input logic [tsched_pkg::TaskW-1:0] next_task_o,
  input logic                         found_o
);

  // request word occupies the block
  a_req_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == tsched_pkg::KindRequest) |=> busy)
    else $error("request did not raise busy");

  // write word leaves the block free
  a_wr_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == tsched_pkg::KindWrite) |=> !busy)
    else $error("write word held busy");

  // result strobe is a single pulse after the scan ends
  a_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_res_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy && $past(busy)))
    else $error("result without finished scan");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> next_task_o == '0)
    else $error("empty ready set gave nonzero task");

endmodule

bind task_scheduler_rr_prio_edf_unit tsched_chk u_tsched_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .kind_i         (kind_i),
  .result_valid_o (result_valid_o),
  .next_task_o    (next_task_o),
  .found_o        (found_o)
);
